// File: sv/esc_pkg.sv
// shared types and constants for the environmental sensor compensation block
// no dependencies
`default_nettype none
package esc_pkg;
    typedef enum logic [2:0] {
        REG_CAL_TEMP     = 3'd0,
        REG_CAL_PRESS_LO = 3'd1,
        REG_CAL_PRESS_HI = 3'd2,
        REG_CAL_PRESS_P9 = 3'd3,
        REG_CAL_HUM      = 3'd4
    } t_reg_idx;

    localparam logic [31:0] C_P_OFFS    = 32'd64000;
    localparam logic [31:0] C_H_OFFS    = 32'd76800;
    localparam logic [31:0] C_H_MAX     = 32'd419430400;
    localparam logic [31:0] C_P_SCALE   = 32'd3125;
    localparam logic [31:0] C_P_BASE    = 32'd1048576;
    localparam logic [31:0] C_MSB       = 32'h80000000;
    localparam logic [31:0] C_H_BIAS    = 32'd2097152;
    localparam logic [31:0] C_32768     = 32'd32768;
    localparam logic [31:0] C_16384     = 32'd16384;
    localparam logic [31:0] C_8192      = 32'd8192;

    // 32x32 product, low word
    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = a * b;
        return p[31:0];
    endfunction

    function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
        return 32'($signed(x) >>> n);
    endfunction
endpackage
`default_nettype wire

// File: sv/esc_div.sv
// pipelined restoring divider, one quotient bit per stage
// depends on nothing but its parameters
`default_nettype none
module esc_div #(
    parameter int unsigned W = 32,
    parameter int unsigned TW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [W-1:0]  i_num,
    input  wire logic [W-1:0]  i_den,
    input  wire logic [TW-1:0] i_tag,
    output logic [W-1:0]       o_quo,
    output logic [TW-1:0]      o_tag
);
    logic [W-1:0]  r_rem [W+1];
    logic [W-1:0]  r_num [W+1];
    logic [W-1:0]  r_den [W+1];
    logic [TW-1:0] r_tag [W+1];

    always_comb begin
        r_rem[0] = '0;
        r_num[0] = i_num;
        r_den[0] = i_den;
        r_tag[0] = i_tag;
    end

    for (genvar s = 0; s < W; s++) begin : g_st
        logic [W:0] n_trial;
        logic [W:0] n_sub;
        assign n_trial = {r_rem[s], r_num[s][W-1]};
        assign n_sub   = n_trial - {1'b0, r_den[s]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1] <= n_sub[W] ? n_trial[W-1:0] : n_sub[W-1:0];
                r_num[s+1] <= {r_num[s][W-2:0], ~n_sub[W]};
                r_den[s+1] <= r_den[s];
                r_tag[s+1] <= r_tag[s];
            end
        end
    end

    assign o_quo = r_num[W];
    assign o_tag = r_tag[W];
endmodule
`default_nettype wire

// File: sv/env_sensor_compensation.sv
// throughput one item per cycle while the output is not stalled (o_valid high with i_ready low)
// a 32-stage pipelined divider for pressure sets the depth; the pipe advances
// whenever its last stage is empty or taken, so a stall holds every stage in place
// reset (synchronous, active low) clears the valid bits and calibration registers
`default_nettype none
module env_sensor_compensation (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [19:0] i_raw_pressure,
    input  wire logic [19:0] i_raw_temperature,
    input  wire logic [15:0] i_raw_humidity,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [23:0]      o_temperature_centi,
    output logic [31:0]      o_pressure_pa,
    output logic [16:0]      o_humidity_q10
);
    import esc_pkg::*;
    localparam int unsigned NPRE = 6;
    localparam int unsigned NDIV = 32;
    localparam int unsigned NPOST = 8;
    localparam int unsigned NTOT = NPRE + NDIV + NPOST;

    logic [47:0] r_cal_t;
    logic [63:0] r_cal_pl, r_cal_ph, r_cal_h;
    logic [15:0] r_cal_p9;
    logic [NTOT-1:0] r_vld;
    logic en;

    assign en = ~r_vld[NTOT-1] | i_ready;
    assign o_ready = en;
    assign o_cfg_ready = 1'b1;
    assign o_valid = r_vld[NTOT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_t <= '0; r_cal_pl <= '0; r_cal_ph <= '0; r_cal_p9 <= '0; r_cal_h <= '0;
            r_vld <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_CAL_TEMP:     r_cal_t  <= i_cfg_data[47:0];
                    REG_CAL_PRESS_LO: r_cal_pl <= i_cfg_data;
                    REG_CAL_PRESS_HI: r_cal_ph <= i_cfg_data;
                    REG_CAL_PRESS_P9: r_cal_p9 <= i_cfg_data[15:0];
                    REG_CAL_HUM:      r_cal_h  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (en) r_vld <= {r_vld[NTOT-2:0], i_valid};
        end
    end

    // coefficients
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, h1, h2, h3, h4, h5, h6;
    assign t1 = {16'd0, r_cal_t[15:0]};
    assign t2 = 32'($signed(r_cal_t[31:16]));
    assign t3 = 32'($signed(r_cal_t[47:32]));
    assign p1 = {16'd0, r_cal_pl[15:0]};
    assign p2 = 32'($signed(r_cal_pl[31:16]));
    assign p3 = 32'($signed(r_cal_pl[47:32]));
    assign p4 = 32'($signed(r_cal_pl[63:48]));
    assign p5 = 32'($signed(r_cal_ph[15:0]));
    assign p6 = 32'($signed(r_cal_ph[31:16]));
    assign p7 = 32'($signed(r_cal_ph[47:32]));
    assign p8 = 32'($signed(r_cal_ph[63:48]));
    assign p9 = 32'($signed(r_cal_p9));
    assign h1 = {24'd0, r_cal_h[7:0]};
    assign h2 = 32'($signed(r_cal_h[23:8]));
    assign h3 = {24'd0, r_cal_h[31:24]};
    assign h4 = 32'($signed(r_cal_h[43:32]));
    assign h5 = 32'($signed(r_cal_h[55:44]));
    assign h6 = 32'($signed(r_cal_h[63:56]));

    // stage 1: temperature products
    logic [19:0] r1_p; logic [15:0] r1_h; logic [31:0] r1_a, r1_cc, r1_c;
    always_ff @(posedge i_clk) if (en) begin
        r1_p  <= i_raw_pressure;
        r1_h  <= i_raw_humidity;
        r1_a  <= mul32({15'd0, i_raw_temperature[19:3]} - (t1 << 1), t2);
        r1_c  <= {16'd0, i_raw_temperature[19:4]} - t1;
        r1_cc <= mul32({16'd0, i_raw_temperature[19:4]} - t1,
                       {16'd0, i_raw_temperature[19:4]} - t1);
    end
    // stage 2: fine temperature
    logic [19:0] r2_p; logic [15:0] r2_h; logic [31:0] r2_fine, r2_b;
    always_ff @(posedge i_clk) if (en) begin
        r2_p <= r1_p; r2_h <= r1_h;
        r2_b <= asr(mul32(asr(r1_cc, 12), t3), 14);
        r2_fine <= asr(r1_a, 11);
    end
    logic [31:0] fine2;
    assign fine2 = r2_fine + r2_b;

    // stage 3: first-level products
    logic [19:0] r3_p; logic [15:0] r3_h; logic [31:0] r3_fine, r3_a, r3_sq, r3_ap5, r3_ap2;
    logic [31:0] r3_vh6, r3_vh3, r3_h5v;
    logic [31:0] a3, a3q, v3;
    assign a3  = asr(fine2, 1) - C_P_OFFS;
    assign a3q = asr(a3, 2);
    assign v3  = fine2 - C_H_OFFS;
    always_ff @(posedge i_clk) if (en) begin
        r3_p <= r2_p; r3_h <= r2_h; r3_fine <= fine2; r3_a <= a3;
        r3_sq  <= mul32(a3q, a3q);
        r3_ap5 <= mul32(a3, p5);
        r3_ap2 <= mul32(p2, a3);
        r3_vh6 <= mul32(v3, h6);
        r3_vh3 <= mul32(v3, h3);
        r3_h5v <= mul32(h5, v3);
    end
    // stage 4
    logic [19:0] r4_p; logic [31:0] r4_fine, r4_b, r4_p3q, r4_ap2, r4_ha, r4_hb;
    always_ff @(posedge i_clk) if (en) begin
        r4_p <= r3_p; r4_fine <= r3_fine; r4_ap2 <= r3_ap2;
        r4_b <= asr(mul32(asr(r3_sq, 11), p6) + (r3_ap5 << 1), 2) + (p4 << 16);
        r4_p3q <= mul32(p3, asr(r3_sq, 13));
        r4_ha <= asr((({16'd0, r3_h} << 14) - (h4 << 20) - r3_h5v) + C_16384, 15);
        r4_hb <= mul32(asr(r3_vh6, 10), asr(r3_vh3, 11) + C_32768);
    end
    // stage 5
    logic [19:0] r5_p; logic [31:0] r5_fine, r5_b, r5_a, r5_ha, r5_hc;
    logic [31:0] hb4;
    assign hb4 = asr(r4_hb, 10) + C_H_BIAS;
    always_ff @(posedge i_clk) if (en) begin
        r5_p <= r4_p; r5_fine <= r4_fine; r5_b <= r4_b; r5_ha <= r4_ha;
        r5_a <= asr(asr(r4_p3q, 3) + asr(r4_ap2, 1), 18);
        r5_hc <= mul32(hb4, h2);
    end
    // stage 6: divisor and numerator, humidity product
    logic [31:0] r6_fine, r6_den, r6_num, r6_hv; logic r6_big;
    logic [31:0] pn5;
    assign pn5 = mul32((C_P_BASE - {12'd0, r5_p}) - asr(r5_b, 12), C_P_SCALE);
    always_ff @(posedge i_clk) if (en) begin
        r6_fine <= r5_fine;
        r6_den  <= asr(mul32(C_32768 + r5_a, p1), 15);
        r6_big  <= pn5 >= C_MSB;
        r6_num  <= (pn5 >= C_MSB) ? pn5 : (pn5 << 1);
        r6_hv   <= mul32(r5_ha, asr(r5_hc + C_8192, 14));
    end

    // divider, side data in tag
    localparam int unsigned TW = 32 + 32 + 1 + 1;
    logic [TW-1:0] dtag;
    logic [31:0] dq;
    logic [TW-1:0] dtag_o;
    esc_div #(.W(32), .TW(TW)) u_div (
        .i_clk(i_clk), .i_en(en), .i_num(r6_num), .i_den(r6_den),
        .i_tag({r6_fine, r6_hv, r6_big, r6_den == '0}), .o_quo(dq), .o_tag(dtag_o)
    );
    assign dtag = dtag_o;

    // post stages: pressure correction, humidity and temperature finish, then output
    logic [31:0] r7_fine, r7_hv, r7_pres; logic r7_z;
    always_ff @(posedge i_clk) if (en) begin
        r7_fine <= dtag[65:34]; r7_hv <= dtag[33:2]; r7_z <= dtag[0];
        r7_pres <= dtag[1] ? (dq << 1) : dq;
    end
    logic [31:0] r8_fine, r8_hv, r8_pres, r8_sq, r8_q; logic r8_z;
    logic [31:0] hq7;
    assign hq7 = asr(r7_hv, 15);
    always_ff @(posedge i_clk) if (en) begin
        r8_fine <= r7_fine; r8_hv <= r7_hv; r8_pres <= r7_pres; r8_z <= r7_z;
        r8_sq <= mul32(r7_pres >> 3, r7_pres >> 3);
        r8_q  <= mul32(hq7, hq7);
    end
    logic [31:0] r9_fine, r9_hv, r9_pres, r9_pa, r9_pb, r9_hq; logic r9_z;
    always_ff @(posedge i_clk) if (en) begin
        r9_fine <= r8_fine; r9_hv <= r8_hv; r9_pres <= r8_pres; r9_z <= r8_z;
        r9_pa <= mul32(p9, r8_sq >> 13);
        r9_pb <= mul32(r8_pres >> 2, p8);
        r9_hq <= mul32(asr(r8_q, 7), h1);
    end
    logic [31:0] r10_fine, r10_pres, r10_hv;
    logic [31:0] hv9;
    assign hv9 = r9_hv - asr(r9_hq, 4);
    always_ff @(posedge i_clk) if (en) begin
        r10_fine <= r9_fine;
        r10_pres <= r9_z ? '0 : r9_pres + asr(asr(r9_pa, 12) + asr(r9_pb, 13) + p7, 4);
        r10_hv <= hv9[31] ? '0 : ((hv9 > C_H_MAX) ? C_H_MAX : hv9);
    end
    logic [31:0] r11_temp, r11_pres, r11_hv;
    always_ff @(posedge i_clk) if (en) begin
        r11_temp <= asr(mul32(r10_fine, 32'd5) + 32'd128, 8);
        r11_pres <= r10_pres; r11_hv <= r10_hv;
    end
    // hold stages to keep latency round
    logic [23:0] r_ot [3]; logic [31:0] r_op [3]; logic [16:0] r_oh [3];
    always_ff @(posedge i_clk) if (en) begin
        r_ot[0] <= r11_temp[23:0]; r_op[0] <= r11_pres; r_oh[0] <= r11_hv[28:12];
        for (int k = 1; k < 3; k++) begin
            r_ot[k] <= r_ot[k-1]; r_op[k] <= r_op[k-1]; r_oh[k] <= r_oh[k-1];
        end
    end
    assign o_temperature_centi = r_ot[2];
    assign o_pressure_pa = r_op[2];
    assign o_humidity_q10 = r_oh[2];
endmodule
`default_nettype wire

// File: sv/esc_checker.sv
// port-level checks for the compensation block, bound to the top level
// depends on env_sensor_compensation ports
`default_nettype none
module esc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [16:0] o_humidity_q10,
    input wire logic [31:0] o_pressure_pa
);
    // humidity never exceeds full scale
    a_hum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_humidity_q10 <= 17'd102400) else $error("humidity out of range");
    // result held while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pressure_pa)) else $error("result dropped");
    // input accepted whenever downstream drains
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ready |-> o_ready) else $error("stall without backpressure");
    // nothing comes out right after reset
    a_rst: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_valid) else $error("valid after reset");
endmodule

bind env_sensor_compensation esc_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_humidity_q10(o_humidity_q10),
    .o_pressure_pa(o_pressure_pa)
);
`default_nettype wire
